>>> design/plh_pkg.sv
package plh_pkg;

    localparam int SITE_IN_W = 8;
    localparam int DUR_W     = 32;
    localparam int CNT_W     = 32;
    localparam int TOT_W     = 48;
    localparam int ST_W      = 20;
    localparam int BIN_OUT_W = 3;

    localparam logic [ST_W-1:0] ST_RESET = 20'd1000;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [TOT_W-1:0] t_tot;
    typedef logic [DUR_W-1:0] t_dur;

    typedef struct packed {
        t_cnt cnt;
        t_tot total;
        t_dur tmin;
        t_dur tmax;
    } t_site_rec;

    typedef struct packed {
        t_cnt cnt;
        t_tot total;
    } t_bin_rec;

    function automatic t_cnt sat_inc(t_cnt v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic t_tot sat_add(t_tot a, t_dur b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {{(TOT_W + 1 - DUR_W){1'b0}}, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

>>> design/per_site_latency_histogram_unit.sv
// Per-site latency histogram. Each input transaction carries a site index and a
// duration; the block updates that site's count, total, min, max and the count and
// time sum of the chosen latency bin, then returns the updated site record and the
// bin. A site index of SITES or more wraps modulo SITES. After reset the block
// clears both tables, one bin entry per cycle, with o_in_ready low;
// second_ticks may be written meanwhile. Items are handled one at a time: after
// the accept the bin divider resolves one quotient bit per cycle, then the
// bin table is read, then the write back updates both tables and the output
// register; the site-table read overlaps the divider. o_in_ready returns in the
// cycle after the write back. Write back waits while an earlier result is still
// held in the output register, which adds one cycle per stalled output cycle.
// A result waits in the output register while the next item is accepted.
module per_site_latency_histogram_unit
    import plh_pkg::*;
#(
    parameter int SITES = 256,
    parameter int BINS  = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ST_W-1:0]       i_second_ticks,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SITE_IN_W-1:0]  i_site,
    input  logic [DUR_W-1:0]      i_duration,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CNT_W-1:0]      o_sample_count,
    output logic [TOT_W-1:0]      o_time_total,
    output logic [DUR_W-1:0]      o_time_min,
    output logic [DUR_W-1:0]      o_time_max,
    output logic [BIN_OUT_W-1:0]  o_bin_index
);

    localparam int SAW = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int BAW = $clog2(SITES * BINS);
    localparam int BW  = $clog2(BINS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIV   = 4'b0100,
        S_WB    = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [BAW-1:0]   r_clr;
    logic [ST_W-1:0]  r_second_ticks;
    logic [SAW-1:0]   r_site;
    logic [DUR_W-1:0] r_dur;
    logic [BAW-1:0]   r_baddr;
    logic             r_out_valid;
    t_site_rec        r_out_rec;
    logic [BIN_OUT_W-1:0] r_out_bin;

    logic [SAW-1:0]   site_map [256];
    logic             in_fire, wb_fire, clr_last, div_done;
    logic [BW-1:0]    div_bin;
    logic [BAW-1:0]   bin_raddr;
    t_site_rec        site_rd, site_new;
    t_bin_rec         bin_rd, bin_new;
    logic             first;

    // site wrap as a constant table
    for (genvar k = 0; k < 256; k++) begin : g_site_map
        assign site_map[k] = SAW'(k % SITES);
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign wb_fire  = (r_state == S_WB) && (!r_out_valid || i_out_ready);
    assign clr_last = (r_clr == BAW'(SITES * BINS - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE:  if (in_fire) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_WB;
            S_WB:    if (wb_fire) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_second_ticks <= ST_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_second_ticks <= i_second_ticks;
            end
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_site <= site_map[i_site];
            r_dur  <= i_duration;
        end
        if (r_state == S_DIV && div_done) begin
            r_baddr <= bin_raddr;
        end
        if (wb_fire) begin
            r_out_rec <= site_new;
            r_out_bin <= BIN_OUT_W'(div_bin);
        end
    end

    plh_bin_div #(.BINS(BINS)) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (in_fire),
        .i_duration     (i_duration),
        .i_second_ticks (r_second_ticks),
        .o_done         (div_done),
        .o_bin          (div_bin)
    );

    assign bin_raddr = BAW'(r_site) * BAW'(BINS) + BAW'(div_bin);

    // read-modify-write of the site record and the bin entry
    assign first            = (site_rd.cnt == '0);
    assign site_new.cnt     = sat_inc(site_rd.cnt);
    assign site_new.total   = sat_add(site_rd.total, r_dur);
    assign site_new.tmin    = (first || r_dur < site_rd.tmin) ? r_dur : site_rd.tmin;
    assign site_new.tmax    = (first || r_dur > site_rd.tmax) ? r_dur : site_rd.tmax;
    assign bin_new.cnt      = sat_inc(bin_rd.cnt);
    assign bin_new.total    = sat_add(bin_rd.total, r_dur);

    plh_ram #(.WIDTH($bits(t_site_rec)), .DEPTH(SITES)) u_site_ram (
        .i_clk   (i_clk),
        .i_we    (((r_state == S_CLEAR) && (r_clr < BAW'(SITES))) || wb_fire),
        .i_waddr ((r_state == S_CLEAR) ? r_clr[SAW-1:0] : r_site),
        .i_wdata ((r_state == S_CLEAR) ? '0 : site_new),
        .i_re    (in_fire),
        .i_raddr (site_map[i_site]),
        .o_rdata (site_rd)
    );

    plh_ram #(.WIDTH($bits(t_bin_rec)), .DEPTH(SITES * BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_CLEAR) || wb_fire),
        .i_waddr ((r_state == S_CLEAR) ? r_clr : r_baddr),
        .i_wdata ((r_state == S_CLEAR) ? '0 : bin_new),
        .i_re    ((r_state == S_DIV) && div_done),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rd)
    );

    assign o_out_valid    = r_out_valid;
    assign o_sample_count = r_out_rec.cnt;
    assign o_time_total   = r_out_rec.total;
    assign o_time_min     = r_out_rec.tmin;
    assign o_time_max     = r_out_rec.tmax;
    assign o_bin_index    = r_out_bin;

endmodule

>>> design/plh_ram.sv
module plh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/plh_bin_div.sv
module plh_bin_div
    import plh_pkg::*;
#(
    parameter int BINS = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DUR_W-1:0]           i_duration,
    input  logic [ST_W-1:0]            i_second_ticks,
    output logic                       o_done,
    output logic [$clog2(BINS)-1:0]    o_bin
);

    localparam int BW     = $clog2(BINS);
    localparam int NW     = ST_W + BW;
    localparam int STEP_W = $clog2(BW + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_big;
    logic [STEP_W-1:0] r_step;
    logic [NW-1:0]     r_rem;
    logic [BW-1:0]     r_quo;

    logic [NW-1:0]     div_shift;
    logic              q_bit;

    assign div_shift = NW'(i_second_ticks) << r_step;
    assign q_bit     = (r_rem >= div_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= NW'(i_duration[ST_W-1:0]) * NW'(BINS - 1);
            r_quo  <= '0;
            r_step <= STEP_W'(BW - 1);
            r_big  <= (i_second_ticks == '0) ||
                      (i_duration >= DUR_W'(i_second_ticks));
        end else if (r_busy) begin
            if (q_bit) begin
                r_rem <= r_rem - div_shift;
            end
            r_quo <= BW'({r_quo, q_bit});
            if (r_step != '0) begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_bin  = r_big ? BW'(BINS - 1) : r_quo;

endmodule

>>> design/plh_checker.sv
module plh_checker
    import plh_pkg::*;
#(
    parameter int BINS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  logic [CNT_W-1:0]      o_sample_count,
    input  logic [TOT_W-1:0]      o_time_total,
    input  logic [DUR_W-1:0]      o_time_min,
    input  logic [DUR_W-1:0]      o_time_max,
    input  logic [BIN_OUT_W-1:0]  o_bin_index
);

    // a stalled result transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_count) &&
        $stable(o_time_total) && $stable(o_time_min) && $stable(o_time_max))
        else $error("result changed while stalled");

    a_rec_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_count != '0) && (o_time_min <= o_time_max) &&
        (o_time_total >= TOT_W'(o_time_max)))
        else $error("inconsistent site record");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (BINS > 8) || (o_bin_index <= BIN_OUT_W'(BINS - 1)))
        else $error("bin index out of range");

    // tables are being cleared right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input accepted during table clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted while busy");

endmodule

bind per_site_latency_histogram_unit plh_checker #(.BINS(BINS)) u_plh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sample_count (o_sample_count),
    .o_time_total   (o_time_total),
    .o_time_min     (o_time_min),
    .o_time_max     (o_time_max),
    .o_bin_index    (o_bin_index)
);
